// ===== src/clt_pkg.sv =====
// shared types and constants for the command line tokenizer
// no dependencies
package clt_pkg;

	localparam int unsigned CMD_BYTES_W = 11;
	localparam int unsigned TOKENS_W    = 7;
	localparam int unsigned INDEX_W     = 6;
	localparam int unsigned CFG_DATA_W  = 11;
	localparam int unsigned CFG_INDEX_W = 1;

	localparam logic [CMD_BYTES_W-1:0] MAX_BUFFER = 11'd1024;
	localparam logic [TOKENS_W-1:0]    MAX_ARGS   = 7'd64;

	localparam logic [CMD_BYTES_W-1:0] RESET_CMD_BYTES = 11'd256;
	localparam logic [TOKENS_W-1:0]    RESET_TOKENS    = 7'd16;

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_CMD_BYTES = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_TOKENS    = 1'd1;

	localparam logic [7:0] CH_ESC   = 8'h5C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;

	typedef enum logic [1:0] {
		KIND_BYTE     = 2'd0,
		KIND_EMPTY    = 2'd1,
		KIND_FINISHED = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TRUNCATED = 3'd1,
		ST_TOO_MANY  = 3'd2,
		ST_SYNTAX    = 3'd3,
		ST_END       = 3'd4
	} status_t;

	typedef struct packed {
		logic [CMD_BYTES_W-1:0] byte_limit;
		logic [TOKENS_W-1:0]    token_limit;
	} limits_t;

	typedef struct packed {
		kind_t                kind;
		logic [7:0]           byte_out;
		logic                 token_start;
		logic [INDEX_W-1:0]   token_index;
		logic [TOKENS_W-1:0]  token_total;
		status_t              status;
	} result_t;

	typedef struct packed {
		logic                   in_quote;
		logic                   in_token;
		logic                   escape_pending;
		logic                   quote_check_pending;
		logic                   discarding;
		status_t                latched_status;
		logic [TOKENS_W-1:0]    tokens_seen;
		logic [CMD_BYTES_W-1:0] bytes_seen;
	} cmd_state_t;

endpackage

// ===== src/clt_cfg.sv =====
// configuration registers, stored already clamped to their legal ranges
// depends on clt_pkg
module clt_cfg import clt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output limits_t                limits
);

	logic [CMD_BYTES_W-1:0] byte_limit_q;
	logic [TOKENS_W-1:0]    token_limit_q;
	logic [CMD_BYTES_W-1:0] bytes_raw;
	logic [TOKENS_W-1:0]    tokens_raw;
	logic [CMD_BYTES_W-1:0] bytes_clamped;
	logic [TOKENS_W-1:0]    tokens_clamped;

	assign bytes_raw  = cfg_data[CMD_BYTES_W-1:0];
	assign tokens_raw = cfg_data[TOKENS_W-1:0];

	// byte limit kept as size minus one
	always_comb begin
		if (bytes_raw < 11'd2) begin
			bytes_clamped = 11'd1;
		end else if (bytes_raw > MAX_BUFFER) begin
			bytes_clamped = MAX_BUFFER - 11'd1;
		end else begin
			bytes_clamped = bytes_raw - 11'd1;
		end
		if (tokens_raw < 7'd1) begin
			tokens_clamped = 7'd1;
		end else if (tokens_raw > MAX_ARGS) begin
			tokens_clamped = MAX_ARGS;
		end else begin
			tokens_clamped = tokens_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_limit_q  <= RESET_CMD_BYTES - 11'd1;
			token_limit_q <= RESET_TOKENS;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MAX_CMD_BYTES: byte_limit_q  <= bytes_clamped;
				REG_MAX_TOKENS:    token_limit_q <= tokens_clamped;
				default: ;
			endcase
		end
	end

	assign limits.byte_limit  = byte_limit_q;
	assign limits.token_limit = token_limit_q;

endmodule

// ===== src/clt_core.sv =====
// per-byte parse step: command state registers and the next-state logic
// depends on clt_pkg
module clt_core import clt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  limits_t    limits,
	input  logic       item_valid,
	input  logic [7:0] char_in,
	input  logic       end_of_input,
	output logic       res_valid,
	output result_t    res
);

	cmd_state_t          st_q;
	cmd_state_t          st_w;
	logic                emit;
	logic                tok_req;
	logic                fin_req;
	logic [TOKENS_W-1:0] tok_idx;

	always_comb begin
		st_w    = st_q;
		emit    = 1'b0;
		res     = '0;
		tok_req = 1'b0;
		fin_req = 1'b0;
		tok_idx = '0;

		if (end_of_input) begin
			st_w       = '0;
			emit       = 1'b1;
			res.kind   = KIND_FINISHED;
			res.status = ST_END;
		end else if (st_q.discarding) begin
			if (char_in == CH_NL) begin
				fin_req = 1'b1;
			end
		end else if (st_q.bytes_seen >= limits.byte_limit) begin
			st_w.discarding = 1'b1;
			if (st_q.latched_status == ST_OK) begin
				st_w.latched_status = ST_TRUNCATED;
			end
			if (char_in == CH_NL) begin
				fin_req = 1'b1;
			end
		end else begin
			st_w.bytes_seen          = st_q.bytes_seen + 11'd1;
			st_w.quote_check_pending = 1'b0;
			if (st_q.quote_check_pending && char_in != CH_SPACE && char_in != CH_NL) begin
				st_w.discarding = 1'b1;
				if (st_q.latched_status == ST_OK) begin
					st_w.latched_status = ST_SYNTAX;
				end
			end else if (st_q.escape_pending) begin
				st_w.escape_pending = 1'b0;
				tok_req             = 1'b1;
			end else if (char_in == CH_ESC) begin
				st_w.escape_pending = 1'b1;
			end else if (char_in == CH_QUOTE) begin
				if (st_q.in_quote && !st_q.in_token) begin
					if (st_q.tokens_seen >= limits.token_limit) begin
						st_w.discarding = 1'b1;
						if (st_q.latched_status == ST_OK) begin
							st_w.latched_status = ST_TOO_MANY;
						end
					end else begin
						st_w.tokens_seen = st_q.tokens_seen + 7'd1;
						st_w.in_quote    = 1'b0;
						emit             = 1'b1;
						res.kind         = KIND_EMPTY;
						res.token_start  = 1'b1;
						res.token_index  = st_q.tokens_seen[INDEX_W-1:0];
					end
				end else begin
					if (st_q.in_token) begin
						st_w.quote_check_pending = 1'b1;
					end
					st_w.in_quote = ~st_q.in_quote;
				end
			end else if (st_q.in_quote) begin
				tok_req = 1'b1;
			end else if (char_in == CH_SPACE) begin
				st_w.in_token = 1'b0;
			end else if (char_in == CH_NL) begin
				fin_req = 1'b1;
			end else begin
				tok_req = 1'b1;
			end
		end

		// token byte, opening a token when none is open, or discarding the command when the token limit is reached
		if (tok_req) begin
			if (!st_w.in_token && st_w.tokens_seen >= limits.token_limit) begin
				st_w.discarding = 1'b1;
				if (st_w.latched_status == ST_OK) begin
					st_w.latched_status = ST_TOO_MANY;
				end
			end else begin
				if (!st_w.in_token) begin
					st_w.tokens_seen = st_w.tokens_seen + 7'd1;
					st_w.in_token    = 1'b1;
					res.token_start  = 1'b1;
				end
				tok_idx         = st_w.tokens_seen - 7'd1;
				emit            = 1'b1;
				res.kind        = KIND_BYTE;
				res.byte_out    = char_in;
				res.token_index = tok_idx[INDEX_W-1:0];
			end
		end

		if (fin_req) begin
			emit            = 1'b1;
			res.kind        = KIND_FINISHED;
			res.status      = st_w.latched_status;
			res.token_total = (st_w.latched_status == ST_SYNTAX) ? '0 : st_w.tokens_seen;
			st_w            = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (item_valid) begin
			st_q <= st_w;
		end
	end

	assign res_valid = item_valid && emit;

endmodule

// ===== src/clt_outbuf.sv =====
// two-entry result buffer between the parse step and the output channel
// depends on clt_pkg
module clt_outbuf import clt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	result_t    slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = out_valid && !out_stall;
	assign out_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign out_data  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== src/command_line_tokenizer.sv =====
// Command line tokenizer, one input byte per request and at most one result per byte:
// token bytes, empty tokens and command-finished reports with count and status.
// Takes one byte every cycle unless the input stalls; a result passes from the byte's
// input register through one parse step into a two-entry result buffer. Input stalls only
// while a byte waits in the input register and the result buffer is full, i.e. while the
// output side stalls.
// depends on clt_pkg, clt_cfg, clt_core, clt_outbuf
module command_line_tokenizer import clt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             char_in,
	input  logic                   end_of_input,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             kind,
	output logic [7:0]             byte_out,
	output logic                   token_start,
	output logic [INDEX_W-1:0]     token_index,
	output logic [TOKENS_W-1:0]    token_total,
	output logic [2:0]             status
);

	limits_t    limits;
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;
	logic       full;
	logic       advance;
	logic       res_valid;
	result_t    res;
	result_t    out_data;

	assign advance  = valid_s1 && !full;
	assign in_stall = valid_s1 && full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_in;
			eoi_s1  <= end_of_input;
		end
	end

	clt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.limits    (limits)
	);

	clt_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.limits       (limits),
		.item_valid   (advance),
		.char_in      (char_s1),
		.end_of_input (eoi_s1),
		.res_valid    (res_valid),
		.res          (res)
	);

	clt_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign kind        = out_data.kind;
	assign byte_out    = out_data.byte_out;
	assign token_start = out_data.token_start;
	assign token_index = out_data.token_index;
	assign token_total = out_data.token_total;
	assign status      = out_data.status;

endmodule

// ===== src/clt_checker.sv =====
// port-level checks for the command line tokenizer, bound to the top level
// depends on clt_pkg and command_line_tokenizer
module clt_checker import clt_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input logic [1:0]          kind,
	input logic [7:0]          byte_out,
	input logic                token_start,
	input logic [TOKENS_W-1:0] token_total,
	input logic [2:0]          status
);

	// held result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(byte_out))
		else $error("stalled result changed");

	// empty token always opens a token with ok status
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_EMPTY |-> token_start && status == ST_OK && byte_out == 8'd0)
		else $error("bad empty token result");

	// finish report carries no byte and opens nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FINISHED |-> !token_start && byte_out == 8'd0)
		else $error("bad finish result");

	// syntax error and end of input report zero tokens
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FINISHED && (status == ST_SYNTAX || status == ST_END)
		|-> token_total == '0)
		else $error("nonzero count on error finish");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.kind        (kind),
	.byte_out    (byte_out),
	.token_start (token_start),
	.token_total (token_total),
	.status      (status)
);

// ===== tb/command_line_tokenizer_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for command_line_tokenizer: directed table, then random command lines
// checked against an in-bench tokenizer model with random idling on both sides
// depends on clt_pkg and the command_line_tokenizer rtl
module command_line_tokenizer_test;
	import clt_pkg::*;

	localparam int HOLD_CYCLES  = 60;
	localparam int SETTLE_CYCLES = 6;
	localparam int N_PHASES     = 7;
	localparam int PHASE_ITEMS  = 36;
	localparam result_t NO_RES  = '0;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_CONFIG} row_use_t;

	typedef struct packed {
		row_use_t               how;
		logic [7:0]             c;
		logic                   eoi;
		result_t                want;
		logic [CFG_INDEX_W-1:0] reg_sel;
		logic [CFG_DATA_W-1:0]  reg_val;
	} stim_row_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cfg_write    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;
	logic                   in_valid     = 1'b0;
	logic                   in_stall;
	logic [7:0]             char_in      = '0;
	logic                   end_of_input = 1'b0;
	logic                   out_valid;
	logic                   out_stall    = 1'b0;
	logic [1:0]             kind;
	logic [7:0]             byte_out;
	logic                   token_start;
	logic [INDEX_W-1:0]     token_index;
	logic [TOKENS_W-1:0]    token_total;
	logic [2:0]             status;

	// model state and limits
	cmd_state_t line_state;
	limits_t    lim;

	result_t    tokenizer_out[$];
	logic [7:0] line_bytes[$];
	stim_row_t  directed_rows[27];

	logic [CFG_DATA_W-1:0] byte_steps[N_PHASES]  = '{11'd2047, 11'd256, 11'd40, 11'd1024,
		11'd1, 11'd12, 11'd0};
	logic [CFG_DATA_W-1:0] token_steps[N_PHASES] = '{11'h7FF, 11'd16, 11'd8, 11'd64,
		11'd0, 11'd3, 11'd0};

	bit      tx_gaps = 1'b1;
	bit      rx_gaps = 1'b1;
	bit      hold_request = 1'b0;
	int      hold_left = 0;
	int      mismatches = 0;
	int      results_checked = 0;
	int      items_offered = 0;
	int      finished_by_status[5] = '{default: 0};
	result_t want;

	command_line_tokenizer u_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic result_t res(kind_t k, logic [7:0] b, logic s, logic [INDEX_W-1:0] i,
		logic [TOKENS_W-1:0] n, status_t st);
		result_t r;
		r = '{k, b, s, i, n, st};
		return r;
	endfunction

	function automatic int unsigned token_cap();
		int unsigned t;
		t = lim.token_limit;
		if (t < 1) t = 1;
		if (t > MAX_ARGS) t = MAX_ARGS;
		return t;
	endfunction

	function automatic void latch_discard(status_t st);
		if (line_state.latched_status == ST_OK) line_state.latched_status = st;
		line_state.discarding = 1'b1;
	endfunction

	function automatic result_t finish_command();
		result_t r;
		r = NO_RES;
		r.kind = KIND_FINISHED;
		r.status = line_state.latched_status;
		r.token_total = (line_state.latched_status == ST_SYNTAX) ? '0 : line_state.tokens_seen;
		line_state = '0;
		return r;
	endfunction

	function automatic bit emit_token_byte(input logic [7:0] c, output result_t r);
		logic first;
		first = 1'b0;
		r = NO_RES;
		if (!line_state.in_token) begin
			if (line_state.tokens_seen >= token_cap()) begin
				latch_discard(ST_TOO_MANY);
				return 1'b0;
			end
			line_state.tokens_seen++;
			line_state.in_token = 1'b1;
			first = 1'b1;
		end
		r.kind = KIND_BYTE;
		r.byte_out = c;
		r.token_start = first;
		r.token_index = INDEX_W'(line_state.tokens_seen - 7'd1);
		return 1'b1;
	endfunction

	// one byte through the tokenizer, returns 1 when it yields a result
	function automatic bit tokenize_byte(input logic [7:0] c, input logic eoi, output result_t r);
		int unsigned cap;
		r = NO_RES;
		if (eoi) begin
			line_state = '0;
			r.kind = KIND_FINISHED;
			r.status = ST_END;
			return 1'b1;
		end
		if (line_state.discarding) begin
			if (c == CH_NL) begin
				r = finish_command();
				return 1'b1;
			end
			return 1'b0;
		end
		cap = lim.byte_limit;
		if (cap < 2) cap = 2;
		if (cap > MAX_BUFFER) cap = MAX_BUFFER;
		if (line_state.bytes_seen >= cap - 1) begin
			latch_discard(ST_TRUNCATED);
			if (c == CH_NL) begin
				r = finish_command();
				return 1'b1;
			end
			return 1'b0;
		end
		line_state.bytes_seen++;
		if (line_state.quote_check_pending) begin
			line_state.quote_check_pending = 1'b0;
			if (c != CH_SPACE && c != CH_NL) begin
				latch_discard(ST_SYNTAX);
				return 1'b0;
			end
		end
		if (line_state.escape_pending) begin
			line_state.escape_pending = 1'b0;
			return emit_token_byte(c, r);
		end
		if (c == CH_ESC) begin
			line_state.escape_pending = 1'b1;
			return 1'b0;
		end
		if (c == CH_QUOTE) begin
			if (line_state.in_quote && !line_state.in_token) begin
				if (line_state.tokens_seen >= token_cap()) begin
					latch_discard(ST_TOO_MANY);
					return 1'b0;
				end
				line_state.tokens_seen++;
				line_state.in_quote = 1'b0;
				r.kind = KIND_EMPTY;
				r.token_start = 1'b1;
				r.token_index = INDEX_W'(line_state.tokens_seen - 7'd1);
				return 1'b1;
			end
			if (line_state.in_token) line_state.quote_check_pending = 1'b1;
			line_state.in_quote = !line_state.in_quote;
			return 1'b0;
		end
		if (line_state.in_quote) return emit_token_byte(c, r);
		if (c == CH_SPACE) begin
			line_state.in_token = 1'b0;
			return 1'b0;
		end
		if (c == CH_NL) begin
			r = finish_command();
			return 1'b1;
		end
		return emit_token_byte(c, r);
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do c = 8'($urandom_range(255));
		while (c == CH_SPACE || c == CH_NL || c == CH_QUOTE || c == CH_ESC);
		return c;
	endfunction

	function automatic void add_plain(int unsigned n);
		repeat (n) line_bytes.push_back(plain_char());
	endfunction

	// contents between quotes: plain bytes, spaces, newlines and escape pairs
	function automatic void add_quoted_body(int unsigned n);
		repeat (n) begin
			case ($urandom_range(5))
				0: line_bytes.push_back(CH_SPACE);
				1: line_bytes.push_back(CH_NL);
				2: begin
					line_bytes.push_back(CH_ESC);
					line_bytes.push_back(8'($urandom_range(255)));
				end
				default: add_plain(1);
			endcase
		end
	endfunction

	function automatic void compose_clean(int unsigned words, bit broken);
		int unsigned bad_at;
		bad_at = broken ? $urandom_range(words - 1) : words;
		if ($urandom_range(3) == 0) line_bytes.push_back(CH_SPACE);
		for (int unsigned w = 0; w < words; w++) begin
			if (w != 0) repeat ($urandom_range(2, 1)) line_bytes.push_back(CH_SPACE);
			if (w == bad_at) begin
				// quote inside a token with no separator after it
				add_plain(1);
				line_bytes.push_back(CH_QUOTE);
				add_plain(1);
			end else begin
				case ($urandom_range(4))
					0: add_plain($urandom_range(4, 1));
					1: begin
						add_plain($urandom_range(2));
						line_bytes.push_back(CH_ESC);
						line_bytes.push_back(8'($urandom_range(255)));
					end
					2: begin
						line_bytes.push_back(CH_QUOTE);
						add_quoted_body($urandom_range(5));
						line_bytes.push_back(CH_QUOTE);
					end
					3: begin
						add_plain($urandom_range(3, 1));
						line_bytes.push_back(CH_QUOTE);
						line_bytes.push_back(CH_SPACE);
						add_quoted_body($urandom_range(4));
						line_bytes.push_back(CH_QUOTE);
					end
					default: begin
						line_bytes.push_back(CH_QUOTE);
						line_bytes.push_back(CH_QUOTE);
					end
				endcase
			end
		end
		line_bytes.push_back(CH_NL);
	endfunction

	function automatic void compose_noise();
		repeat ($urandom_range(12, 1)) begin
			case ($urandom_range(7))
				0: line_bytes.push_back(CH_SPACE);
				1: line_bytes.push_back(CH_QUOTE);
				2: line_bytes.push_back(CH_ESC);
				3: line_bytes.push_back(CH_NL);
				default: line_bytes.push_back(8'($urandom_range(255)));
			endcase
		end
		line_bytes.push_back(CH_NL);
	endfunction

	function automatic void compose_long(int unsigned word_len, int unsigned words);
		repeat (words) begin
			add_plain(word_len);
			line_bytes.push_back(CH_SPACE);
		end
		line_bytes.push_back(CH_NL);
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic offer(input logic [7:0] c, input logic eoi, input bit typed,
		input result_t typed_want);
		result_t r;
		bit produced;
		if (tx_gaps) begin
			while ($urandom_range(99) < 36) begin
				in_valid <= 1'b0;
				char_in <= 8'($urandom_range(255));
				end_of_input <= 1'($urandom_range(1));
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		char_in <= c;
		end_of_input <= eoi;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		produced = tokenize_byte(c, eoi, r);
		if (typed) r = typed_want;
		if (typed || produced) begin
			tokenizer_out.push_back(r);
			if (r.kind == KIND_FINISHED) finished_by_status[r.status]++;
		end
		items_offered++;
		@(negedge clk);
	endtask

	task automatic send_line();
		while (line_bytes.size() != 0) offer(line_bytes.pop_front(), 1'b0, 1'b0, NO_RES);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tokenizer_out.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (sel == REG_MAX_CMD_BYTES) lim.byte_limit = val;
		else lim.token_limit = val[TOKENS_W-1:0];
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] got);
		if (got !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got);
			mismatches++;
		end
	endtask

	// receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (rx_gaps) begin
			out_stall <= ($urandom_range(99) < 36);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (tokenizer_out.size() == 0) begin
				$display("%0t: result with none expected, expected none, actual kind %0h byte %0h",
					$time, kind, byte_out);
				mismatches++;
			end else begin
				want = tokenizer_out.pop_front();
				check_field("kind", 8'(want.kind), 8'(kind));
				check_field("byte_out", want.byte_out, byte_out);
				check_field("token_start", 8'(want.token_start), 8'(token_start));
				check_field("token_index", 8'(want.token_index), 8'(token_index));
				check_field("token_total", 8'(want.token_total), 8'(token_total));
				check_field("status", 8'(want.status), 8'(status));
				results_checked++;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		line_state = '0;
		lim = '{RESET_CMD_BYTES, RESET_TOKENS};
		byte_steps[N_PHASES-1] = CFG_DATA_W'($urandom_range(64, 2));
		token_steps[N_PHASES-1] = CFG_DATA_W'($urandom_range(10, 1));
		directed_rows = '{
			'{ROW_TYPED, 8'hFF, 1'b1, res(KIND_FINISHED, 8'h00, 1'b0, 6'd0, 7'd0, ST_END),
				REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_TYPED, 8'h00, 1'b0, res(KIND_BYTE, 8'h00, 1'b1, 6'd0, 7'd0, ST_OK),
				REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_TYPED, 8'hFF, 1'b0, res(KIND_BYTE, 8'hFF, 1'b0, 6'd0, 7'd0, ST_OK),
				REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_PREDICT, CH_SPACE, 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_PREDICT, CH_QUOTE, 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_TYPED, CH_QUOTE, 1'b0, res(KIND_EMPTY, 8'h00, 1'b1, 6'd1, 7'd0, ST_OK),
				REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_PREDICT, CH_QUOTE, 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_PREDICT, CH_SPACE, 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_PREDICT, CH_NL, 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_PREDICT, CH_QUOTE, 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_PREDICT, CH_SPACE, 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_PREDICT, CH_ESC, 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_PREDICT, CH_NL, 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_TYPED, CH_NL, 1'b0, res(KIND_FINISHED, 8'h00, 1'b0, 6'd0, 7'd4, ST_OK),
				REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_PREDICT, "a", 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_PREDICT, CH_QUOTE, 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_PREDICT, "b", 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_TYPED, CH_NL, 1'b0, res(KIND_FINISHED, 8'h00, 1'b0, 6'd0, 7'd0, ST_SYNTAX),
				REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_CONFIG, 8'h00, 1'b0, NO_RES, REG_MAX_TOKENS, 11'd1},
			'{ROW_PREDICT, "a", 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_PREDICT, CH_SPACE, 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_PREDICT, "b", 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_TYPED, CH_NL, 1'b0, res(KIND_FINISHED, 8'h00, 1'b0, 6'd0, 7'd1, ST_TOO_MANY),
				REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_CONFIG, 8'h00, 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_PREDICT, "a", 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_PREDICT, "b", 1'b0, NO_RES, REG_MAX_CMD_BYTES, 11'd0},
			'{ROW_TYPED, CH_NL, 1'b0, res(KIND_FINISHED, 8'h00, 1'b0, 6'd0, 7'd1, ST_TRUNCATED),
				REG_MAX_CMD_BYTES, 11'd0}
		};

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			case (directed_rows[i].how)
				ROW_CONFIG: begin
					wait_drained();
					write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
				end
				ROW_TYPED: begin
					offer(directed_rows[i].c, directed_rows[i].eoi, 1'b1, directed_rows[i].want);
				end
				default: begin
					offer(directed_rows[i].c, directed_rows[i].eoi, 1'b0, NO_RES);
				end
			endcase
		end

		for (int p = 0; p < N_PHASES; p++) begin
			int goal;
			int pick;
			wait_drained();
			write_reg(REG_MAX_CMD_BYTES, byte_steps[p]);
			write_reg(REG_MAX_TOKENS, token_steps[p]);
			tx_gaps = (p != 2);
			rx_gaps = (p != 2);
			if (p == 1) begin
				// receiver holds off while requests keep coming, then sender waits for all results
				hold_request = 1'b1;
				compose_long(3, 12);
				send_line();
				wait_drained();
			end
			if (p == 3) begin
				compose_long(1, 70);
				send_line();
				compose_clean(3, 1'b0);
				add_plain(5);
				send_line();
				offer(8'($urandom_range(255)), 1'b1, 1'b0, NO_RES);
			end
			goal = items_offered + PHASE_ITEMS;
			while (items_offered < goal) begin
				pick = $urandom_range(99);
				if (pick < 3) offer(8'($urandom_range(255)), 1'b1, 1'b0, NO_RES);
				else if (pick < 15) compose_noise();
				else if (pick < 30) compose_clean($urandom_range(5, 1), 1'b1);
				else compose_clean($urandom_range(5, 1), 1'b0);
				send_line();
			end
		end

		wait_drained();
		$display("%0d requests sent over %0d limit settings, %0d results checked",
			items_offered, N_PHASES + 3, results_checked);
		$display("commands finished ok/truncated/too many/syntax/end: %0d/%0d/%0d/%0d/%0d",
			finished_by_status[0], finished_by_status[1], finished_by_status[2],
			finished_by_status[3], finished_by_status[4]);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
